// File: rtl/pwl_cal_pkg.sv
// Package for the piecewise-linear calibration table.
// Item types, sizes, controller states and command/status groups.
// No dependencies.
`timescale 1ns / 1ps

package pwl_cal_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CFG_W      = 5;
	localparam int DIV_STEPS  = 32;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        point_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] y_value;
		logic [3:0]         bin_index;
		logic               clamped;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_SCAN,
		ST_MUL,
		ST_SIGN,
		ST_DIV,
		ST_FIX,
		ST_PUT
	} state_t;

	typedef enum logic [1:0] {
		RD_ZERO,
		RD_LAST,
		RD_ONE,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    wr_point;
		logic    take_query;
		rd_sel_t rd_sel;
		logic    save_first;
		logic    clamp_lo;
		logic    clamp_hi;
		logic    scan_next;
		logic    load_ops;
		logic    mul;
		logic    sign;
		logic    div_step;
		logic    fix;
		logic    push;
	} cmd_t;

	typedef struct packed {
		logic lo_hit;
		logic hi_hit;
		logic bin_hit;
		logic bin_end;
		logic den_zero;
		logic div_last;
		logic slot_free;
	} sts_t;

endpackage

// File: rtl/pwl_cal_ctrl.sv
// Sequencer for the calibration table: write, clamp checks, bin scan, divide.
// Depends on pwl_cal_pkg.
`timescale 1ns / 1ps

module pwl_cal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               req_lookup,
	output logic               in_ready,
	input  pwl_cal_pkg::sts_t  sts,
	output pwl_cal_pkg::cmd_t  cmd
);
	import pwl_cal_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && req_lookup) state_d = ST_FETCH;
			end
			ST_FETCH:  state_d = ST_CHK_LO;
			ST_CHK_LO: state_d = sts.lo_hit ? ST_PUT : ST_CHK_HI;
			ST_CHK_HI: state_d = sts.hi_hit ? ST_PUT : ST_SCAN;
			ST_SCAN: begin
				if (sts.bin_hit || sts.bin_end) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_SIGN;
			ST_SIGN: state_d = sts.den_zero ? ST_FIX : ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_d = ST_FIX;
			end
			ST_FIX: state_d = ST_PUT;
			ST_PUT: begin
				if (sts.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_ZERO;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.wr_point   = in_valid && !req_lookup;
				cmd.take_query = in_valid && req_lookup;
			end
			ST_FETCH: cmd.rd_sel = RD_ZERO;
			ST_CHK_LO: begin
				cmd.rd_sel     = RD_LAST;
				cmd.save_first = 1'b1;
				cmd.clamp_lo   = sts.lo_hit;
			end
			ST_CHK_HI: begin
				cmd.rd_sel   = RD_ONE;
				cmd.clamp_hi = sts.hi_hit;
			end
			ST_SCAN: begin
				cmd.rd_sel    = RD_NEXT;
				cmd.load_ops  = sts.bin_hit || sts.bin_end;
				cmd.scan_next = !(sts.bin_hit || sts.bin_end);
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_SIGN: cmd.sign = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FIX:  cmd.fix = 1'b1;
			ST_PUT:  cmd.push = sts.slot_free;
			default: cmd = '0;
		endcase
	end

	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_lookup) |=> state_q == ST_FETCH)
		else $error("accepted lookup did not start the sequence");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> state_q == ST_DIV)
		else $error("divide left early");

	a_put_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && !sts.slot_free) |=> state_q == ST_PUT)
		else $error("result dropped while output slot busy");

endmodule

// File: rtl/pwl_cal_dp.sv
// Datapath: point stores, bin scan registers, multiplier, restoring divider,
// result and output registers. Depends on pwl_cal_pkg.
`timescale 1ns / 1ps

module pwl_cal_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_wdata,
	input  pwl_cal_pkg::in_item_t  in_data,
	input  pwl_cal_pkg::cmd_t      cmd,
	output pwl_cal_pkg::sts_t      sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pwl_cal_pkg::out_item_t out_data
);
	import pwl_cal_pkg::*;

	logic signed [15:0] x_mem [MAX_POINTS];
	logic signed [15:0] y_mem [MAX_POINTS];

	logic [IDX_W-1:0]   last_q;
	logic signed [15:0] qx_q;
	logic [IDX_W-1:0]   rd_addr;
	logic signed [15:0] rd_x_q;
	logic signed [15:0] rd_y_q;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [16:0] dx_q;
	logic signed [16:0] dy_q;
	logic signed [16:0] den_q;
	logic signed [15:0] y0_q;
	logic signed [33:0] prod_q;
	logic [31:0]        quo_q;
	logic [15:0]        rem_q;
	logic [15:0]        dvs_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic [16:0]        div_trial;
	logic               div_ge;
	logic signed [33:0] q_signed;
	logic signed [34:0] sum;
	logic signed [15:0] sum_sat;

	// point count register, kept as index of the last point in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= IDX_W'(1);
		end else if (cfg_we) begin
			if (cfg_wdata < CFG_W'(2)) begin
				last_q <= IDX_W'(1);
			end else if (cfg_wdata > CFG_W'(MAX_POINTS)) begin
				last_q <= IDX_W'(MAX_POINTS - 1);
			end else begin
				last_q <= IDX_W'(cfg_wdata - CFG_W'(1));
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_LAST: rd_addr = last_q;
			RD_ONE:  rd_addr = IDX_W'(1);
			RD_NEXT: rd_addr = idx_q + IDX_W'(2);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_point && (int'(in_data.point_index) < MAX_POINTS)) begin
			x_mem[IDX_W'(in_data.point_index)] <= in_data.point_x;
			y_mem[IDX_W'(in_data.point_index)] <= in_data.point_y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	assign div_trial = {rem_q, quo_q[31]};
	assign div_ge    = div_trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.take_query) qx_q <= in_data.query_x;
		if (cmd.save_first || cmd.scan_next) begin
			prev_x_q <= rd_x_q;
			prev_y_q <= rd_y_q;
		end
		if (cmd.load_ops) begin
			dx_q  <= {qx_q[15], qx_q} - {prev_x_q[15], prev_x_q};
			dy_q  <= {rd_y_q[15], rd_y_q} - {prev_y_q[15], prev_y_q};
			den_q <= {rd_x_q[15], rd_x_q} - {prev_x_q[15], prev_x_q};
			y0_q  <= prev_y_q;
		end
		if (cmd.mul) prod_q <= dx_q * dy_q;
		if (cmd.sign) begin
			quo_q <= prod_q[33] ? 32'(-prod_q) : prod_q[31:0];
			dvs_q <= den_q[16] ? 16'(-den_q) : den_q[15:0];
			neg_q <= prod_q[33] ^ den_q[16];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? 16'(div_trial - {1'b0, dvs_q}) : div_trial[15:0];
			quo_q <= {quo_q[30:0], div_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.save_first) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.sign) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	assign q_signed = (den_q == '0) ? '0 :
		(neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
	assign sum = {{19{y0_q[15]}}, y0_q} + {q_signed[33], q_signed};

	always_comb begin
		if (sum > 35'sd32767) begin
			sum_sat = 16'sh7fff;
		end else if (sum < -35'sd32768) begin
			sum_sat = 16'sh8000;
		end else begin
			sum_sat = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp_lo) begin
			res_q.y_value   <= rd_y_q;
			res_q.bin_index <= '0;
			res_q.clamped   <= 1'b1;
		end else if (cmd.clamp_hi) begin
			res_q.y_value   <= rd_y_q;
			res_q.bin_index <= 4'(last_q);
			res_q.clamped   <= 1'b1;
		end else if (cmd.fix) begin
			res_q.y_value   <= sum_sat;
			res_q.bin_index <= 4'(idx_q);
			res_q.clamped   <= 1'b0;
		end
		if (cmd.push) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.lo_hit    = qx_q <= rd_x_q;
	assign sts.hi_hit    = qx_q >= rd_x_q;
	assign sts.bin_hit   = (qx_q >= prev_x_q) && (qx_q <= rd_x_q);
	assign sts.bin_end   = idx_q == (last_q - IDX_W'(1));
	assign sts.den_zero  = den_q == '0;
	assign sts.div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over an unread transfer");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_next |-> (idx_q < last_q - IDX_W'(1)))
		else $error("bin scan ran past the last point");

	a_clamp_hi_bin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clamp_hi |=> (res_q.bin_index == 4'($past(last_q)) && res_q.clamped))
		else $error("high clamp result has wrong bin");

endmodule

// File: rtl/piecewise_linear_cal_table.sv
// Piecewise-linear calibration table, top level: controller plus datapath.
// Point write: taken while idle. Clamped lookup: result from the end point, no scan or divide.
// Interpolated lookup: scans 1..points-1 bins, one store read per cycle, then multiplies
// and runs the one-bit-per-cycle divider (skipped for zero-width bins).
// One item at a time; a new item is taken while a result waits. Async active-low reset
// clears control; point stores are undefined until written and are not cleared.
`timescale 1ns / 1ps

module piecewise_linear_cal_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pwl_cal_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pwl_cal_pkg::out_item_t out_data
);
	import pwl_cal_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pwl_cal_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.req_lookup (in_data.req_type == REQ_LOOKUP),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	pwl_cal_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for piecewise_linear_cal_table: point writes, lookups and point-count settings
// with random handshake gaps, each lookup checked against a built-in interpolation predictor.
// Depends on pwl_cal_pkg and the piecewise_linear_cal_table RTL.

module testbench;
	import pwl_cal_pkg::*;

	localparam int RANDOM_ITEMS  = 700;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int LONG_HOLD     = 400;
	localparam int X_STEP        = 4369;
	localparam logic [4:0] FIRST_SETTINGS [6] = '{5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd2};

	class cal_lookup_scoreboard;
		logic signed [15:0] x_tab [MAX_POINTS];
		logic signed [15:0] y_tab [MAX_POINTS];
		logic [4:0] point_count;
		out_item_t expected_lookups [$];
		int fail_count;

		function new();
			for (int i = 0; i < MAX_POINTS; i++) begin
				x_tab[i] = '0;
				y_tab[i] = '0;
			end
			point_count = 5'd2;
			fail_count = 0;
		endfunction

		function void set_point_count(logic [4:0] v);
			point_count = v;
		endfunction

		function int points_used();
			int n;
			n = point_count;
			if (n < 2) n = 2;
			if (n > MAX_POINTS) n = MAX_POINTS;
			return n;
		endfunction

		function out_item_t interpolate(logic signed [15:0] qx);
			out_item_t r;
			int last, bin;
			bit found;
			longint x, x0, x1, y0, y1, yv;
			last = points_used() - 1;
			x = qx;
			r.clamped = 1'b0;
			if (x <= x_tab[0]) begin
				yv = y_tab[0];
				bin = 0;
				r.clamped = 1'b1;
			end else if (x >= x_tab[last]) begin
				yv = y_tab[last];
				bin = last;
				r.clamped = 1'b1;
			end else begin
				bin = last - 1;
				found = 1'b0;
				for (int i = 0; i < last && !found; i++)
					if (x >= x_tab[i] && x <= x_tab[i + 1]) begin
						bin = i;
						found = 1'b1;
					end
				x0 = x_tab[bin];
				x1 = x_tab[bin + 1];
				y0 = y_tab[bin];
				y1 = y_tab[bin + 1];
				// flat bin: no division
				if (x1 == x0) yv = y0;
				else yv = y0 + (x - x0) * (y1 - y0) / (x1 - x0);
			end
			if (yv > 32767) yv = 32767;
			if (yv < -32768) yv = -32768;
			r.y_value = 16'(yv);
			r.bin_index = 4'(bin);
			return r;
		endfunction

		function void note_transfer(in_item_t it);
			if (it.req_type == REQ_WRITE) begin
				x_tab[it.point_index] = it.point_x;
				y_tab[it.point_index] = it.point_y;
			end else begin
				expected_lookups.insert(expected_lookups.size(), interpolate(it.query_x));
			end
		endfunction

		function void check_lookup(out_item_t got);
			out_item_t want;
			if (expected_lookups.size() == 0) begin
				$error("result with no lookup pending: y_value %0d bin_index %0d clamped %0d",
					got.y_value, got.bin_index, got.clamped);
				fail_count++;
				return;
			end
			want = expected_lookups.pop_front();
			if (got.y_value !== want.y_value) begin
				$error("y_value: expected %0d, got %0d", want.y_value, got.y_value);
				fail_count++;
			end
			if (got.bin_index !== want.bin_index) begin
				$error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
				fail_count++;
			end
			if (got.clamped !== want.clamped) begin
				$error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
				fail_count++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [4:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	cal_lookup_scoreboard sb = new();
	int cycle_count = 0;
	int items_sent = 0;
	int lookups_done = 0;
	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;

	piecewise_linear_cal_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int draw_gap(bit quiet);
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.req_type    = 1'($urandom);
		it.point_index = 4'($urandom);
		it.point_x     = 16'($urandom);
		it.point_y     = 16'($urandom);
		it.query_x     = 16'($urandom);
		return it;
	endfunction

	// valid stays high across back-to-back items; settle() drops it
	task automatic send_item(in_item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0) quiet_send = !quiet_send;
		gap = draw_gap(quiet_send);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_transfer(it);
		items_sent++;
	endtask

	task automatic send_write(int idx, int px, int py);
		in_item_t it;
		it = noise_item();
		it.req_type    = REQ_WRITE;
		it.point_index = 4'(idx);
		it.point_x     = 16'(px);
		it.point_y     = 16'(py);
		send_item(it);
	endtask

	task automatic send_lookup(int qx);
		in_item_t it;
		it = noise_item();
		it.req_type = REQ_LOOKUP;
		it.query_x  = 16'(qx);
		send_item(it);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_points(logic [4:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_point_count(v);
	endtask

	function automatic int pick_query();
		int n, lo, hi, k, p;
		n = sb.points_used();
		lo = sb.x_tab[0];
		hi = sb.x_tab[n - 1];
		k = $urandom_range(0, 19);
		if (k < 11 && lo <= hi) return lo + int'($urandom_range(0, hi - lo));
		p = sb.x_tab[$urandom_range(0, n - 1)];
		if (k < 14) return p;
		if (k == 14 && p > -32768) return p - 1;
		if (k == 15 && p < 32767) return p + 1;
		if (k == 16) return -32768;
		if (k == 17) return 32767;
		return $signed(16'($urandom));
	endfunction

	// ascending table, sometimes with a repeated x or the full code range
	task automatic load_table();
		int xs [$];
		int ys [$];
		int k;
		for (int i = 0; i < MAX_POINTS; i++) begin
			xs.insert(i, $signed(16'($urandom)));
			ys.insert(i, $signed(16'($urandom)));
		end
		xs.sort();
		case ($urandom_range(0, 3))
			0: begin
				k = $urandom_range(0, MAX_POINTS - 2);
				xs[k + 1] = xs[k];
			end
			1: begin
				xs[0] = -32768;
				xs[MAX_POINTS - 1] = 32767;
				ys[0] = 32767;
				ys[MAX_POINTS - 1] = -32768;
			end
			default: ;
		endcase
		if ($urandom_range(0, 1) == 0)
			for (int i = 0; i < MAX_POINTS; i++) send_write(i, xs[i], ys[i]);
		else
			for (int i = MAX_POINTS - 1; i >= 0; i--) send_write(i, xs[i], ys[i]);
	endtask

	initial begin
		int base;
		int phase;
		in_item_t it;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full table, evenly spaced x with one repeated point
		for (int i = 0; i < MAX_POINTS; i++)
			send_write(i, -32768 + ((i == 6) ? 5 : i) * X_STEP, (i % 2) ? -32768 : 32767);
		send_lookup(-32768);
		send_lookup(32767);
		send_lookup(-30000);
		set_points(5'd16);
		send_lookup(32767);
		send_lookup(32766);
		send_lookup(-32768 + 5 * X_STEP);
		send_lookup(-32768 + 5 * X_STEP + 1);
		send_lookup(0);
		send_lookup(-32767);
		// two points spanning the whole range: largest product
		set_points(5'd2);
		send_write(1, 32767, -32768);
		send_lookup(32766);
		send_lookup(-32767);
		// both ends at the same x: low clamp wins
		send_write(1, -32768, 0);
		send_lookup(0);
		send_lookup(-32768);

		base = items_sent;
		phase = 0;
		while (items_sent < base + RANDOM_ITEMS) begin
			set_points(phase < 6 ? FIRST_SETTINGS[phase] : 5'($urandom_range(0, 31)));
			if ($urandom_range(0, 3) != 0) begin
				load_table();
				repeat ($urandom_range(15, 40)) send_lookup(pick_query());
			end else begin
				repeat (20) begin
					it = noise_item();
					if (it.req_type == REQ_LOOKUP && $urandom_range(0, 1) == 0)
						it.query_x = 16'(pick_query());
					send_item(it);
				end
			end
			phase++;
		end

		settle();
		if (sb.fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) quiet_recv = !quiet_recv;
			stall = draw_gap(quiet_recv);
			// long hold-off so the block backs up onto its input
			if (lookups_done == 120 || lookups_done == 350) stall = LONG_HOLD;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_lookup(out_data);
			lookups_done++;
		end
	end

endmodule
